### rtl/tiex_pkg.sv
// Package for the tiny ISA execute unit: widths, codes, payload structs and helpers.
// Self-contained; used by every RTL file of the block.
`default_nettype none

package tiex_pkg;

  // Storage sizes. The local store depth is a power of two, so an address is a bit-slice.
  localparam int NUM_REGS  = 6;
  localparam int MEM_DEPTH = 256;

  // Fixed field widths.
  localparam int CmdW     = 3;
  localparam int RegNumW  = 3;
  localparam int DataW    = 8;
  localparam int CycW     = 8;
  localparam int CntW     = 32;
  localparam int RegIdxW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int MemAddrW = $clog2(MEM_DEPTH);

  // Cycle costs and configuration reset values.
  localparam logic [CycW-1:0] BASE_CYCLES     = CycW'(1);
  localparam logic [CycW-1:0] CMP_CYCLES      = CycW'(2);
  localparam logic [CycW-1:0] HIT_CYCLES_RST  = CycW'(2);
  localparam logic [CycW-1:0] MISS_CYCLES_RST = CycW'(40);

  typedef enum logic [CmdW-1:0] {
    CMD_MOV = 3'd0,
    CMD_ADD = 3'd1,
    CMD_CMP = 3'd2,
    CMD_JE  = 3'd3,
    CMD_JMP = 3'd4,
    CMD_ST  = 3'd5,
    CMD_LD  = 3'd6
  } cmd_e;

  typedef enum logic {
    CFG_HIT_CYCLES  = 1'b0,
    CFG_MISS_CYCLES = 1'b1
  } cfg_reg_e;

  // Input word: one decoded instruction.
  typedef struct packed {
    cmd_e                     cmd;
    logic [RegNumW-1:0]       reg_a;
    logic [RegNumW-1:0]       reg_b;
    logic                     use_immediate;
    logic signed [DataW-1:0]  immediate;
  } tiex_in_t;

  // Output word: status after one instruction.
  typedef struct packed {
    logic             equal_flag;
    logic             jump_taken;
    logic             memory_hit;
    logic [CycW-1:0]  cycles_added;
    logic [CntW-1:0]  executed_count;
    logic [CntW-1:0]  cycle_count;
    logic [CntW-1:0]  hit_count;
    logic [CntW-1:0]  memory_op_count;
  } tiex_out_t;

  // Register file write port (register numbers are 1-based).
  typedef struct packed {
    logic               en;
    logic [RegNumW-1:0] num;
    logic [DataW-1:0]   data;
  } rf_wr_t;

  // Register file read result: vld is low for a never-written or out-of-range register.
  typedef struct packed {
    logic             vld;
    logic [DataW-1:0] data;
  } rf_rd_t;

  // Local store access request.
  typedef struct packed {
    logic                st_en;
    logic                ld_en;
    logic [MemAddrW-1:0] addr;
    logic [DataW-1:0]    wdata;
  } dm_req_t;

  // True for register numbers 1 to NUM_REGS.
  function automatic logic reg_ok(input logic [RegNumW-1:0] num);
    return (num != '0) && (int'(num) <= NUM_REGS);
  endfunction

  // Zero-based array index of a 1-based register number.
  function automatic logic [RegIdxW-1:0] reg_idx(input logic [RegNumW-1:0] num);
    logic [RegNumW-1:0] m1;
    m1 = num - RegNumW'(1);
    return RegIdxW'(m1);
  endfunction

  // Local store address of a register value taken as an unsigned byte.
  function automatic logic [MemAddrW-1:0] mem_addr(input logic [DataW-1:0] v);
    return v[MemAddrW-1:0];
  endfunction

  // Saturating 32-bit add.
  function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? '1 : s[CntW-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/tiny_isa_execute_unit.sv
// Top level of the tiny ISA execute unit. Instantiates the register file, the local
// store and the execute stage. Uses tiex_pkg.
//
// The unit takes one instruction word per cycle and returns one status word per
// instruction. The register file is read on the accept edge, the instruction
// executes in the execute stage (stores write and loads read the local store there), and
// the status word then sits in the output register while the register write-back of
// that instruction is made; recent write-backs are forwarded to the execute stage, so
// dependent instructions run back to back. A stalled output holds the whole pipe.
// Configuration writes are taken in any cycle.
`default_nettype none

module tiny_isa_execute_unit import tiex_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_ready_o,
  input  wire tiex_in_t        in_data_i,
  output      logic            out_valid_o,
  input  wire logic            out_ready_i,
  output      tiex_out_t       out_data_o,
  input  wire logic            cfg_valid_i,
  output      logic            cfg_ready_o,
  input  wire cfg_reg_e        cfg_index_i,
  input  wire logic [CycW-1:0] cfg_data_i
);

  logic             adv;
  logic             s1_valid_q;
  tiex_in_t         s1_q;
  logic             out_valid_q;
  tiex_out_t        out_q;
  logic             wb_en_q, wb_ld_q;
  logic [RegNumW-1:0] wb_num_q;
  logic [DataW-1:0] wb_data_q;
  rf_wr_t           prev_q;
  rf_wr_t           wb_pend, rf_wr, ex_wr;
  rf_rd_t           rd_a, rd_b;
  dm_req_t          dm_req;
  logic             mark;
  logic [DataW-1:0] dm_rdata;
  logic             ex_ld;
  tiex_out_t        ex_res;
  logic [CycW-1:0]  hit_cycles_q, miss_cycles_q;

  // The pipe moves whenever the output register is free or being emptied.
  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Pending write-back of the instruction in the output register.
  always_comb begin
    wb_pend.en   = out_valid_q && wb_en_q;
    wb_pend.num  = wb_num_q;
    wb_pend.data = wb_ld_q ? dm_rdata : wb_data_q;
    rf_wr        = wb_pend;
    rf_wr.en     = wb_pend.en && adv;
  end

  tiex_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (adv),
    .rd_a_num_i (in_data_i.reg_a),
    .rd_b_num_i (in_data_i.reg_b),
    .wr_i       (rf_wr),
    .rd_a_o     (rd_a),
    .rd_b_o     (rd_b)
  );

  tiex_dmem u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (dm_req),
    .mark_o  (mark),
    .rdata_o (dm_rdata)
  );

  tiex_execute u_execute (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .valid_i       (s1_valid_q),
    .instr_i       (s1_q),
    .rd_a_i        (rd_a),
    .rd_b_i        (rd_b),
    .wb_pend_i     (wb_pend),
    .wb_prev_i     (prev_q),
    .mark_i        (mark),
    .hit_cycles_i  (hit_cycles_q),
    .miss_cycles_i (miss_cycles_q),
    .dm_req_o      (dm_req),
    .wr_o          (ex_wr),
    .ld_wr_o       (ex_ld),
    .res_o         (ex_res)
  );

  // Pipeline control state and the forwarding copy of the last committed write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wb_en_q     <= 1'b0;
      prev_q      <= '0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      out_valid_q <= s1_valid_q;
      wb_en_q     <= s1_valid_q && ex_wr.en;
      prev_q      <= rf_wr;
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q      <= in_data_i;
      out_q     <= ex_res;
      wb_num_q  <= ex_wr.num;
      wb_data_q <= ex_wr.data;
      wb_ld_q   <= ex_ld;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cycles_q  <= HIT_CYCLES_RST;
      miss_cycles_q <= MISS_CYCLES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HIT_CYCLES:  hit_cycles_q  <= cfg_data_i;
        CFG_MISS_CYCLES: miss_cycles_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/tiex_regfile.sv
// Register file of the execute unit: a small two-read, one-write synchronous memory.
// Per-entry written bits make never-written registers read as zero. Uses tiex_pkg.
`default_nettype none

module tiex_regfile import tiex_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               rd_en_i,
  input  wire logic [RegNumW-1:0] rd_a_num_i,
  input  wire logic [RegNumW-1:0] rd_b_num_i,
  input  wire rf_wr_t             wr_i,
  output      rf_rd_t             rd_a_o,
  output      rf_rd_t             rd_b_o
);

  logic [DataW-1:0]    mem [NUM_REGS];
  logic [NUM_REGS-1:0] written_q;
  logic [RegIdxW-1:0]  idx_a, idx_b, idx_w;
  logic                ok_a, ok_b, ok_w;
  logic [DataW-1:0]    data_a_q, data_b_q;
  logic                vld_a_q, vld_b_q;

  // Address decode; out-of-range numbers read entry 0 and are flagged invalid.
  always_comb begin
    ok_a  = reg_ok(rd_a_num_i);
    ok_b  = reg_ok(rd_b_num_i);
    ok_w  = reg_ok(wr_i.num);
    idx_a = ok_a ? reg_idx(rd_a_num_i) : '0;
    idx_b = ok_b ? reg_idx(rd_b_num_i) : '0;
    idx_w = ok_w ? reg_idx(wr_i.num) : '0;
  end

  // Array write and registered reads (read-before-write on the same edge).
  always_ff @(posedge clk_i) begin
    if (wr_i.en && ok_w) begin
      mem[idx_w] <= wr_i.data;
    end
    if (rd_en_i) begin
      data_a_q <= mem[idx_a];
      data_b_q <= mem[idx_b];
    end
  end

  // Written bits and their registered read copies.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
    end else begin
      if (wr_i.en && ok_w) begin
        written_q[idx_w] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_a_q <= ok_a && written_q[idx_a];
        vld_b_q <= ok_b && written_q[idx_b];
      end
    end
  end

  // An invalid entry reads as zero.
  always_comb begin
    rd_a_o.vld  = vld_a_q;
    rd_a_o.data = vld_a_q ? data_a_q : '0;
    rd_b_o.vld  = vld_b_q;
    rd_b_o.data = vld_b_q ? data_b_q : '0;
  end

endmodule

`default_nettype wire

### rtl/tiex_dmem.sv
// Local store of the execute unit: a single-port synchronous byte memory with
// one valid mark per address held in flip-flops. Uses tiex_pkg.
`default_nettype none

module tiex_dmem import tiex_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dm_req_t          req_i,
  output      logic             mark_o,
  output      logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0]     mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] mark_q;
  logic [DataW-1:0]     rdata_q;

  // The mark of the requested address is looked up in the same cycle.
  assign mark_o  = mark_q[req_i.addr];
  assign rdata_o = rdata_q;

  // Store write and registered load read.
  always_ff @(posedge clk_i) begin
    if (req_i.st_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.ld_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  // A store marks its address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= '0;
    end else if (req_i.st_en) begin
      mark_q[req_i.addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/tiex_execute.sv
// Execute stage logic: operand forwarding, instruction decode, ALU, cycle costs,
// compare flag and saturating counters. Uses tiex_pkg.
`default_nettype none

module tiex_execute import tiex_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             valid_i,
  input  wire tiex_in_t         instr_i,
  input  wire rf_rd_t           rd_a_i,
  input  wire rf_rd_t           rd_b_i,
  input  wire rf_wr_t           wb_pend_i,
  input  wire rf_wr_t           wb_prev_i,
  input  wire logic             mark_i,
  input  wire logic [CycW-1:0]  hit_cycles_i,
  input  wire logic [CycW-1:0]  miss_cycles_i,
  output      dm_req_t          dm_req_o,
  output      rf_wr_t           wr_o,
  output      logic             ld_wr_o,
  output      tiex_out_t        res_o
);

  logic             flag_q, flag_d;
  logic [CntW-1:0]  exec_q, exec_d;
  logic [CntW-1:0]  cyc_q, cyc_d;
  logic [CntW-1:0]  hits_q, hits_d;
  logic [CntW-1:0]  mops_q, mops_d;
  logic [DataW-1:0] op_a, op_b, operand;
  logic             executed, taken, hit, is_st, is_ld, cnt_hit;
  logic [CycW-1:0]  cyc;

  // Newest value of a register: pending write-back, then the write that landed
  // on the read edge, then the array.
  function automatic logic [DataW-1:0] fwd(input logic [RegNumW-1:0] num,
                                           input rf_rd_t             rd,
                                           input rf_wr_t             pend,
                                           input rf_wr_t             prev);
    logic [DataW-1:0] v;
    v = rd.data;
    if (prev.en && prev.num == num) begin
      v = prev.data;
    end
    if (pend.en && pend.num == num) begin
      v = pend.data;
    end
    return v;
  endfunction

  // Operand selection.
  always_comb begin
    op_a    = fwd(instr_i.reg_a, rd_a_i, wb_pend_i, wb_prev_i);
    op_b    = fwd(instr_i.reg_b, rd_b_i, wb_pend_i, wb_prev_i);
    operand = instr_i.use_immediate ? instr_i.immediate : op_b;
  end

  // Instruction decode and execution.
  always_comb begin
    flag_d   = flag_q;
    executed = 1'b0;
    taken    = 1'b0;
    hit      = 1'b0;
    cnt_hit  = 1'b0;
    is_st    = 1'b0;
    is_ld    = 1'b0;
    cyc      = '0;
    wr_o.en   = 1'b0;
    wr_o.num  = instr_i.reg_a;
    wr_o.data = operand;
    case (instr_i.cmd)
      CMD_MOV: begin
        wr_o.en  = reg_ok(instr_i.reg_a);
        cyc      = BASE_CYCLES;
        executed = 1'b1;
      end
      CMD_ADD: begin
        wr_o.en   = reg_ok(instr_i.reg_a);
        wr_o.data = op_a + operand;
        cyc       = BASE_CYCLES;
        executed  = 1'b1;
      end
      CMD_CMP: begin
        flag_d   = (op_a == op_b);
        cyc      = CMP_CYCLES;
        executed = 1'b1;
      end
      CMD_JE: begin
        cyc      = BASE_CYCLES;
        executed = 1'b1;
      end
      CMD_JMP: begin
        if (!flag_q) begin
          cyc      = BASE_CYCLES;
          executed = 1'b1;
          taken    = 1'b1;
        end
      end
      CMD_ST: begin
        is_st    = 1'b1;
        executed = 1'b1;
        hit      = mark_i;
        cnt_hit  = mark_i;
        cyc      = mark_i ? hit_cycles_i : miss_cycles_i;
      end
      CMD_LD: begin
        is_ld    = 1'b1;
        executed = 1'b1;
        cnt_hit  = 1'b1;
        hit      = mark_i;
        wr_o.en  = mark_i && reg_ok(instr_i.reg_a);
        cyc      = mark_i ? hit_cycles_i : '0;
      end
      default: begin
      end
    endcase
  end

  // Loads read the slot a register names in its b field, stores the one named in a.
  always_comb begin
    dm_req_o.st_en = adv_i && valid_i && is_st;
    dm_req_o.ld_en = adv_i && valid_i && is_ld;
    dm_req_o.addr  = is_ld ? mem_addr(op_b) : mem_addr(op_a);
    dm_req_o.wdata = op_b;
    ld_wr_o        = is_ld;
  end

  // Counter updates.
  always_comb begin
    exec_d = executed ? sat_add(exec_q, CntW'(1)) : exec_q;
    cyc_d  = sat_add(cyc_q, CntW'(cyc));
    hits_d = cnt_hit ? sat_add(hits_q, CntW'(1)) : hits_q;
    mops_d = (is_st || is_ld) ? sat_add(mops_q, CntW'(1)) : mops_q;
  end

  // Result word built from the state after this instruction.
  always_comb begin
    res_o.equal_flag      = flag_d;
    res_o.jump_taken      = taken;
    res_o.memory_hit      = hit;
    res_o.cycles_added    = cyc;
    res_o.executed_count  = exec_d;
    res_o.cycle_count     = cyc_d;
    res_o.hit_count       = hits_d;
    res_o.memory_op_count = mops_d;
  end

  // Architectural state commits when the instruction leaves this stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
      exec_q <= '0;
      cyc_q  <= '0;
      hits_q <= '0;
      mops_q <= '0;
    end else if (adv_i && valid_i) begin
      flag_q <= flag_d;
      exec_q <= exec_d;
      cyc_q  <= cyc_d;
      hits_q <= hits_d;
      mops_q <= mops_d;
    end
  end

endmodule

`default_nettype wire

### tb/testbench.sv
// Testbench for tiny_isa_execute_unit: random and directed instruction words with
// idling on both sides, checked against a cycle-free model of the execute unit.
// Depends on tiex_pkg and the RTL of the block.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tiex_pkg::*;

  // Command code 7 is not an operation; the block must leave its state alone.
  localparam cmd_e CMD_UNUSED = cmd_e'(3'd7);
  localparam int HOLD_CYCLES = 300;
  localparam int WORDS_PER_PHASE = 215;

  // Model of the execute unit and store of the status words it predicts.
  class exec_scoreboard;
    logic [DataW-1:0] regs [1:NUM_REGS];
    logic [DataW-1:0] store_bytes [MEM_DEPTH];
    bit               written [MEM_DEPTH];
    bit               eq_flag;
    logic [CntW-1:0]  n_executed, n_cycles, n_hits, n_memops;
    logic [CycW-1:0]  hit_cost, miss_cost;
    tiex_out_t        expected_status [$];
    int               failures;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (written[i]) written[i] = 1'b0;
      eq_flag    = 1'b0;
      n_executed = '0;
      n_cycles   = '0;
      n_hits     = '0;
      n_memops   = '0;
      hit_cost   = HIT_CYCLES_RST;
      miss_cost  = MISS_CYCLES_RST;
      failures   = 0;
    endfunction

    function void set_cost(cfg_reg_e idx, logic [CycW-1:0] value);
      if (idx == CFG_HIT_CYCLES) begin
        hit_cost = value;
      end else begin
        miss_cost = value;
      end
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // Register numbers outside 1..NUM_REGS read as zero and ignore writes.
    function logic [DataW-1:0] read_reg(logic [RegNumW-1:0] n);
      if (n == 0 || n > NUM_REGS) return '0;
      return regs[n];
    endfunction

    function void write_reg(logic [RegNumW-1:0] n, logic [DataW-1:0] v);
      if (n != 0 && n <= NUM_REGS) regs[n] = v;
    endfunction

    function logic [CntW-1:0] add_saturated(logic [CntW-1:0] a, logic [CntW-1:0] b);
      return (a > ~b) ? '1 : a + b;
    endfunction

    // Execute one accepted instruction word and queue the status word it causes.
    function void note_instruction(tiex_in_t w);
      logic [DataW-1:0] operand;
      logic [CntW-1:0]  cost;
      bit               ran;
      int               a;
      tiex_out_t        s;
      s       = '0;
      cost    = '0;
      ran     = 1'b0;
      operand = w.use_immediate ? w.immediate : read_reg(w.reg_b);
      case (w.cmd)
        CMD_MOV: begin
          write_reg(w.reg_a, operand);
          cost = CntW'(BASE_CYCLES);
          ran  = 1'b1;
        end
        CMD_ADD: begin
          write_reg(w.reg_a, read_reg(w.reg_a) + operand);
          cost = CntW'(BASE_CYCLES);
          ran  = 1'b1;
        end
        CMD_CMP: begin
          eq_flag = (read_reg(w.reg_a) == read_reg(w.reg_b));
          cost    = CntW'(CMP_CYCLES);
          ran     = 1'b1;
        end
        CMD_JE: begin
          cost = CntW'(BASE_CYCLES);
          ran  = 1'b1;
        end
        CMD_JMP: begin
          // A jump only counts while the flag is clear.
          if (!eq_flag) begin
            cost         = CntW'(BASE_CYCLES);
            ran          = 1'b1;
            s.jump_taken = 1'b1;
          end
        end
        CMD_ST: begin
          a        = int'(read_reg(w.reg_a)) % MEM_DEPTH;
          ran      = 1'b1;
          n_memops = add_saturated(n_memops, 1);
          if (written[a]) begin
            s.memory_hit = 1'b1;
            n_hits       = add_saturated(n_hits, 1);
            cost         = CntW'(hit_cost);
          end else begin
            written[a] = 1'b1;
            cost       = CntW'(miss_cost);
          end
          store_bytes[a] = read_reg(w.reg_b);
        end
        CMD_LD: begin
          // A load counts as a hit even when the address was never written.
          a        = int'(read_reg(w.reg_b)) % MEM_DEPTH;
          ran      = 1'b1;
          n_memops = add_saturated(n_memops, 1);
          n_hits   = add_saturated(n_hits, 1);
          if (written[a]) begin
            s.memory_hit = 1'b1;
            write_reg(w.reg_a, store_bytes[a]);
            cost = CntW'(hit_cost);
          end
        end
        default: begin
        end
      endcase
      if (ran) n_executed = add_saturated(n_executed, 1);
      n_cycles          = add_saturated(n_cycles, cost);
      s.equal_flag      = eq_flag;
      s.cycles_added    = cost[CycW-1:0];
      s.executed_count  = n_executed;
      s.cycle_count     = n_cycles;
      s.hit_count       = n_hits;
      s.memory_op_count = n_memops;
      expected_status.push_back(s);
    endfunction

    function string describe(tiex_out_t s);
      return $sformatf("flag=%0d taken=%0d hit=%0d cyc=%0d exec=%0d cycles=%0d hits=%0d mem=%0d",
                       s.equal_flag, s.jump_taken, s.memory_hit, s.cycles_added,
                       s.executed_count, s.cycle_count, s.hit_count, s.memory_op_count);
    endfunction

    // Compare one status word from the block with the oldest prediction.
    function void check_status(tiex_out_t got);
      tiex_out_t want;
      string     bad;
      if (expected_status.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected status word: %s", describe(got));
        return;
      end
      want = expected_status.pop_front();
      bad  = "";
      if (got.equal_flag !== want.equal_flag) bad = {bad, " equal_flag"};
      if (got.jump_taken !== want.jump_taken) bad = {bad, " jump_taken"};
      if (got.memory_hit !== want.memory_hit) bad = {bad, " memory_hit"};
      if (got.cycles_added !== want.cycles_added) bad = {bad, " cycles_added"};
      if (got.executed_count !== want.executed_count) bad = {bad, " executed_count"};
      if (got.cycle_count !== want.cycle_count) bad = {bad, " cycle_count"};
      if (got.hit_count !== want.hit_count) bad = {bad, " hit_count"};
      if (got.memory_op_count !== want.memory_op_count) bad = {bad, " memory_op_count"};
      if (bad != "") begin
        failures++;
        if (failures <= 10) begin
          $display("status mismatch in%s", bad);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready_o;
  tiex_in_t         in_data = '0;
  logic             out_valid_o;
  logic             out_ready = 1'b0;
  tiex_out_t        out_data_o;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready_o;
  cfg_reg_e         cfg_index = CFG_HIT_CYCLES;
  logic [CycW-1:0]  cfg_data = '0;

  exec_scoreboard sb = new();

  int burst_left = 0;
  int words_sent = 0;

  // Receiver state: a rotating ready pattern and long hold-offs on request.
  logic [15:0] ready_pattern = '1;
  int          pattern_pos = 0;
  int          hold_left = 0;
  int          hold_asks = 0;
  int          hold_served = 0;

  tiny_isa_execute_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("FAIL tiny_isa_execute_unit");
    $finish;
  end

  // Accepted words on both channels go to the scoreboard in acceptance order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) sb.note_instruction(in_data);
      if (out_valid_o && out_ready) sb.check_status(out_data_o);
    end
  end

  function automatic logic [15:0] next_ready_pattern();
    case ($urandom_range(0, 3))
      0: return '1;
      1: return 16'($urandom);
      2: return 16'($urandom | $urandom);
      default: return 16'($urandom & $urandom);
    endcase
  endfunction

  // Receiver: follows its pattern, or holds off for a counted stretch when asked.
  always @(posedge clk_i) begin
    if (hold_asks != hold_served) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready   <= ready_pattern[pattern_pos];
      pattern_pos <= (pattern_pos + 1) % 16;
      if (pattern_pos == 15) ready_pattern <= next_ready_pattern();
    end
  end

  function automatic tiex_in_t instr(cmd_e c, int ra, int rb, bit ui, int imm);
    tiex_in_t w;
    w.cmd           = c;
    w.reg_a         = RegNumW'(ra);
    w.reg_b         = RegNumW'(rb);
    w.use_immediate = ui;
    w.immediate     = DataW'(imm);
    return w;
  endfunction

  // Mostly valid register numbers, now and then zero or the top code.
  function automatic int pick_reg();
    if ($urandom_range(0, 24) == 0) return $urandom_range(0, 1) ? 0 : (1 << RegNumW) - 1;
    return $urandom_range(1, NUM_REGS);
  endfunction

  // Small values keep addresses and compares colliding often.
  function automatic int pick_imm();
    return $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255);
  endfunction

  function automatic tiex_in_t random_word();
    int   r;
    cmd_e c;
    r = $urandom_range(0, 99);
    if (r < 20) c = CMD_MOV;
    else if (r < 35) c = CMD_ADD;
    else if (r < 47) c = CMD_CMP;
    else if (r < 52) c = CMD_JE;
    else if (r < 62) c = CMD_JMP;
    else if (r < 79) c = CMD_ST;
    else if (r < 96) c = CMD_LD;
    else c = CMD_UNUSED;
    return instr(c, pick_reg(), pick_reg(), 1'($urandom_range(0, 1)), pick_imm());
  endfunction

  // Offer one instruction word in bursts with random gaps; returns at acceptance.
  task automatic send_word(tiex_in_t w);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // Stop offering and wait until every predicted status word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Write both cost registers back to back; valid stays high between them.
  task automatic write_costs(logic [CycW-1:0] hit_value, logic [CycW-1:0] miss_value);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_HIT_CYCLES;
    cfg_data  <= hit_value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_cost(CFG_HIT_CYCLES, hit_value);
    cfg_index <= CFG_MISS_CYCLES;
    cfg_data  <= miss_value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_cost(CFG_MISS_CYCLES, miss_value);
    cfg_valid <= 1'b0;
  endtask

  // Address and data setup, a store then a load through the same address register, then a compare and a JMP or JE.
  task automatic send_store_load_sequence();
    int addr_reg, data_reg, dst_reg, addr;
    addr_reg = $urandom_range(1, NUM_REGS);
    data_reg = 1 + (addr_reg + $urandom_range(0, NUM_REGS - 2)) % NUM_REGS;
    dst_reg  = $urandom_range(1, NUM_REGS);
    addr     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 31);
    send_word(instr(CMD_MOV, addr_reg, pick_reg(), 1'b1, addr));
    send_word(instr($urandom_range(0, 1) ? CMD_ADD : CMD_MOV, data_reg, pick_reg(),
                    1'b1, $urandom_range(0, 255)));
    send_word(instr(CMD_ST, addr_reg, data_reg, 1'($urandom_range(0, 1)), pick_imm()));
    send_word(instr(CMD_LD, dst_reg, addr_reg, 1'($urandom_range(0, 1)), pick_imm()));
    send_word(instr(CMD_CMP, dst_reg, data_reg, 1'($urandom_range(0, 1)), pick_imm()));
    send_word(instr($urandom_range(0, 1) ? CMD_JMP : CMD_JE, pick_reg(), pick_reg(),
                    1'($urandom_range(0, 1)), pick_imm()));
  endtask

  // Field extremes, every operation and the corner cases, at the reset costs.
  task automatic run_directed();
    send_word(instr(CMD_MOV, 1, 0, 1'b1, 127));
    send_word(instr(CMD_MOV, 2, 0, 1'b1, -128));
    send_word(instr(CMD_ADD, 1, 2, 1'b0, 0));
    send_word(instr(CMD_ADD, 1, 0, 1'b1, 127));
    send_word(instr(CMD_MOV, 0, 0, 1'b1, 5));
    send_word(instr(CMD_MOV, 7, 7, 1'b1, 8'h55));
    send_word(instr(CMD_MOV, 3, 0, 1'b0, -1));
    send_word(instr(CMD_MOV, 4, 7, 1'b0, 0));
    send_word(instr(CMD_CMP, 3, 4, 1'b0, 0));
    send_word(instr(CMD_JMP, 0, 0, 1'b0, 0));
    send_word(instr(CMD_JE, 7, 7, 1'b1, -1));
    send_word(instr(CMD_CMP, 1, 2, 1'b0, 0));
    send_word(instr(CMD_JMP, 7, 7, 1'b1, 0));
    send_word(instr(CMD_ST, 1, 2, 1'b0, 0));
    send_word(instr(CMD_ST, 1, 3, 1'b0, 0));
    send_word(instr(CMD_LD, 5, 1, 1'b0, 0));
    send_word(instr(CMD_LD, 6, 2, 1'b0, 0));
    send_word(instr(CMD_MOV, 6, 0, 1'b1, -1));
    send_word(instr(CMD_ST, 6, 1, 1'b0, 0));
    send_word(instr(CMD_LD, 5, 6, 1'b0, 0));
    send_word(instr(CMD_ST, 3, 6, 1'b0, 0));
    send_word(instr(CMD_LD, 2, 0, 1'b0, 0));
    send_word(instr(CMD_UNUSED, 7, 7, 1'b1, -1));
    send_word(instr(CMD_MOV, 1, 5, 1'b0, 99));
    send_word(instr(CMD_CMP, 7, 0, 1'b0, 0));
  endtask

  // One random phase: mostly well-formed store/load sequences, the rest loose words.
  task automatic run_phase(int count, bit with_hold, bit with_drain);
    int stop_at, half_way;
    bit hold_done, drain_done;
    stop_at    = words_sent + count;
    half_way   = words_sent + count / 2;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    while (words_sent < stop_at) begin
      if (with_hold && !hold_done && words_sent >= half_way) begin
        hold_asks <= hold_asks + 1;
        hold_done = 1'b1;
      end
      if (with_drain && !drain_done && words_sent >= half_way) begin
        wait_drained();
        drain_done = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        send_store_load_sequence();
      end else begin
        repeat ($urandom_range(1, 5)) send_word(random_word());
      end
    end
  endtask

  initial begin
    int i;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_phase(WORDS_PER_PHASE, 1'b0, 1'b0);
    wait_drained();
    write_costs(8'd255, 8'd0);
    run_phase(WORDS_PER_PHASE, 1'b1, 1'b0);
    wait_drained();
    write_costs(8'd0, 8'd255);
    run_phase(WORDS_PER_PHASE, 1'b0, 1'b1);
    wait_drained();
    write_costs(CycW'($urandom_range(0, 255)), CycW'($urandom_range(0, 255)));
    run_phase(WORDS_PER_PHASE, 1'b0, 1'b0);
    wait_drained();
    write_costs(8'd255, 8'd255);
    run_phase(WORDS_PER_PHASE, 1'b1, 1'b0);
    wait_drained();
    write_costs(8'd0, 8'd0);
    run_phase(WORDS_PER_PHASE, 1'b0, 1'b1);
    wait_drained();
    write_costs(HIT_CYCLES_RST, MISS_CYCLES_RST);
    run_phase(WORDS_PER_PHASE, 1'b0, 1'b0);

    // Let the pipe empty, then keep watching for stray words.
    in_valid <= 1'b0;
    for (i = 0; i < 20000 && sb.pending() != 0; i++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS tiny_isa_execute_unit");
    end else begin
      $display("FAIL tiny_isa_execute_unit");
    end
    $finish;
  end

endmodule
